// ----- rtl/sso_pkg.sv -----
// Shared constants, types and defaults for the stereo sine oscillator.
`timescale 1ns / 1ps
package sso_pkg;

  // Default geometry of the oscillator
  localparam int PHASE_BITS_DEF       = 24;
  localparam int SINE_TABLE_DEPTH_DEF = 1024;
  localparam int SAMPLE_BITS_DEF      = 16;

  // Shared multiplier operand width (signed)
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // Quarter-wave sine polynomial coefficients, Q30
  localparam logic [30:0] Q30_ONE = 31'd1073741824;
  localparam logic [30:0] POLY_A  = 31'd1686629713;
  localparam logic [30:0] POLY_B  = 31'd690630741;
  localparam logic [30:0] POLY_C  = 31'd77742852;

  // Configuration register resets and limits
  localparam logic [15:0] GLIDE_RESET = 16'd6554;
  localparam logic [12:0] BLOCK_RESET = 13'd1024;
  localparam logic [12:0] MAX_BLOCK   = 13'd4096;
  localparam int          APB_ADDR_W  = 3;

  // One finished stereo pair from the core
  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } sso_result_t;

endpackage

// ----- rtl/sso_mul.sv -----
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
module sso_mul import sso_pkg::*; #(
  parameter int W = MUL_W
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

// ----- rtl/sso_core.sv -----
// Sequencer and datapath: sine, gain, pan and glide through one shared multiplier.
`timescale 1ns / 1ps
module sso_core import sso_pkg::*; #(
  parameter int PHASE_BITS       = PHASE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
  parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [23:0] phase_step,
  input  logic [15:0] pan_target,
  input  logic [15:0] amp_target,
  input  logic [15:0] glide_coefficient,
  output logic        ready,
  output logic        res_valid,
  input  logic        res_take,
  output sso_result_t res
);

  // Table depth must be a power of two
  localparam int LOG2D = $clog2(SINE_TABLE_DEPTH);
  localparam logic signed [33:0] SMAX = (34'sd1 <<< (SAMPLE_BITS - 1)) - 34'sd1;
  localparam logic signed [33:0] OSC_HALF = 34'sd1 <<< (30 - SAMPLE_BITS);
  localparam logic signed [PROD_W-1:0] AMP_HALF = PROD_W'(1) <<< (SAMPLE_BITS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_OSC, S_AMP, S_PANR, S_PANL, S_MIXL, S_MIXR, S_GLP, S_GLA, S_DONE
  } state_t;

  typedef struct packed {
    logic        neg;
    logic [30:0] x;
  } sine_arg_t;

  // Fold a Q0.32 cycle fraction into the first quadrant
  function automatic sine_arg_t sine_arg(input logic [31:0] f);
    sine_arg_t r;
    r.neg = f[31];
    r.x   = f[30] ? (Q30_ONE - {1'b0, f[29:0]}) : {1'b0, f[29:0]};
    return r;
  endfunction

  state_t                   state;
  logic                     wb;
  logic [1:0]               sidx;
  logic [PHASE_BITS-1:0]    phase;
  logic [15:0]              pan;
  logic [15:0]              amp;
  logic [15:0]              pan_t;
  logic [15:0]              amp_t;
  logic                     sine_neg;
  logic [30:0]              x_q;
  logic [30:0]              x2_q;
  logic [30:0]              y_q;
  logic signed [SAMPLE_BITS-1:0] sine_q;
  logic signed [16:0]       s_q;
  logic signed [16:0]       gr_q;
  logic signed [16:0]       gl_q;
  logic signed [15:0]       left_q;
  logic signed [15:0]       right_q;

  logic                     mul_en;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  logic [30:0]              p30;
  logic signed [31:0]       v;
  logic signed [33:0]       osc_r;
  logic signed [33:0]       gain_r;
  logic signed [PROD_W-1:0] r_sb;
  logic signed [PROD_W-1:0] r15;
  logic signed [PROD_W-1:0] r16;
  logic signed [15:0]       mix_sat;
  logic signed [SAMPLE_BITS-1:0] osc_sat;
  logic signed [16:0]       dpan;
  logic signed [16:0]       damp;
  logic signed [17:0]       glide_sum;
  logic [15:0]              glide_sat;
  logic [31:0]              f_osc;
  logic [31:0]              f_panr;

  sso_mul #(.W(MUL_W)) u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_comb begin
    f_osc  = {phase[PHASE_BITS-1 -: LOG2D], {(32 - LOG2D){1'b0}}};
    f_panr = {1'b0, pan, 15'b0};
    dpan   = $signed({1'b0, pan_t}) - $signed({1'b0, pan});
    damp   = $signed({1'b0, amp_t}) - $signed({1'b0, amp});

    p30    = prod[60:30];
    v      = sine_neg ? -$signed({1'b0, p30}) : $signed({1'b0, p30});
    osc_r  = (34'(v) + OSC_HALF) >>> (31 - SAMPLE_BITS);
    gain_r = (34'(v) + 34'sd16384) >>> 15;
    r_sb   = (prod + AMP_HALF) >>> SAMPLE_BITS;
    r15    = (prod + PROD_W'(16384)) >>> 15;
    r16    = (prod + PROD_W'(32768)) >>> 16;

    if (osc_r > SMAX) begin
      osc_sat = SAMPLE_BITS'(SMAX);
    end else if (osc_r < -SMAX) begin
      osc_sat = SAMPLE_BITS'(-SMAX);
    end else begin
      osc_sat = SAMPLE_BITS'(osc_r);
    end

    if (r15 > PROD_W'(32767)) begin
      mix_sat = 16'sh7fff;
    end else if (r15 < -PROD_W'(32768)) begin
      mix_sat = 16'sh8000;
    end else begin
      mix_sat = 16'(r15);
    end

    glide_sum = (state == S_GLP) ? ($signed({2'b0, pan}) + 18'(r16))
                                 : ($signed({2'b0, amp}) + 18'(r16));
    if (glide_sum < 18'sd0) begin
      glide_sat = 16'd0;
    end else if (glide_sum > 18'sd65535) begin
      glide_sat = 16'hffff;
    end else begin
      glide_sat = 16'(glide_sum);
    end
  end

  // Operand select for the shared multiplier
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state) inside
      S_OSC, S_PANR, S_PANL: begin
        mul_en = !wb;
        case (sidx)
          2'd0: begin
            mul_a = $signed(MUL_W'(x_q));
            mul_b = $signed(MUL_W'(x_q));
          end
          2'd1: begin
            mul_a = $signed(MUL_W'(POLY_C));
            mul_b = $signed(MUL_W'(x2_q));
          end
          2'd2: begin
            mul_a = $signed(MUL_W'(y_q));
            mul_b = $signed(MUL_W'(x2_q));
          end
          default: begin
            mul_a = $signed(MUL_W'(y_q));
            mul_b = $signed(MUL_W'(x_q));
          end
        endcase
      end
      S_AMP: begin
        mul_en = !wb;
        mul_a  = MUL_W'(sine_q);
        mul_b  = $signed(MUL_W'(amp));
      end
      S_MIXL: begin
        mul_en = !wb;
        mul_a  = MUL_W'(s_q);
        mul_b  = MUL_W'(gl_q);
      end
      S_MIXR: begin
        mul_en = !wb;
        mul_a  = MUL_W'(s_q);
        mul_b  = MUL_W'(gr_q);
      end
      S_GLP: begin
        mul_en = !wb;
        mul_a  = MUL_W'(dpan);
        mul_b  = $signed(MUL_W'(glide_coefficient));
      end
      S_GLA: begin
        mul_en = !wb;
        mul_a  = MUL_W'(damp);
        mul_b  = $signed(MUL_W'(glide_coefficient));
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wb    <= 1'b0;
      sidx  <= 2'd0;
      phase <= '0;
      pan   <= '0;
      amp   <= '0;
    end else begin
      unique case (state) inside
        S_IDLE: begin
          if (start) begin
            {sine_neg, x_q} <= sine_arg(f_osc);
            phase <= phase + PHASE_BITS'(phase_step);
            pan_t <= pan_target;
            amp_t <= amp_target;
            wb    <= 1'b0;
            sidx  <= 2'd0;
            state <= S_OSC;
          end
        end
        S_OSC, S_PANR, S_PANL: begin
          wb <= !wb;
          if (wb) begin
            sidx <= sidx + 2'd1;
            case (sidx)
              2'd0: x2_q <= p30;
              2'd1: y_q  <= POLY_B - p30;
              2'd2: y_q  <= POLY_A - p30;
              default: begin
                if (state == S_OSC) begin
                  sine_q <= osc_sat;
                  state  <= S_AMP;
                end else if (state == S_PANR) begin
                  gr_q  <= 17'(gain_r);
                  {sine_neg, x_q} <= sine_arg(f_panr + 32'h4000_0000);
                  state <= S_PANL;
                end else begin
                  gl_q  <= 17'(gain_r);
                  state <= S_MIXL;
                end
              end
            endcase
          end
        end
        S_AMP: begin
          wb <= !wb;
          if (wb) begin
            s_q   <= 17'(r_sb);
            {sine_neg, x_q} <= sine_arg(f_panr);
            state <= S_PANR;
          end
        end
        S_MIXL: begin
          wb <= !wb;
          if (wb) begin
            left_q <= mix_sat;
            state  <= S_MIXR;
          end
        end
        S_MIXR: begin
          wb <= !wb;
          if (wb) begin
            right_q <= mix_sat;
            state   <= S_GLP;
          end
        end
        S_GLP: begin
          wb <= !wb;
          if (wb) begin
            pan   <= glide_sat;
            state <= S_GLA;
          end
        end
        S_GLA: begin
          wb <= !wb;
          if (wb) begin
            amp   <= glide_sat;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign ready     = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res.left  = left_q;
  assign res.right = right_q;

endmodule

// ----- rtl/stereo_sine_oscillator_with_glide.sv -----
// Top level: APB registers, input handshake, block counter and output word register.
`timescale 1ns / 1ps
// Stereo sine oscillator with equal-power pan and glide.
//
// Each input word is one sample tick: phase_step, pan_target, amp_target.
// The block answers every input word with exactly one output word:
// left_sample, right_sample and last_of_block (high on the final sample of
// each block of block_length samples). Both channels use valid/ready.
//
// Datapath: one shared 33x33 multiplier computes 17 products per sample
// (oscillator sine, amplitude, two pan gains, two channel mixes, two glide
// steps), one after another. An output word becomes valid in the same cycle
// that in_ready rises again. in_ready stays low while a sample is in work, so
// a new input word waits until the previous sample has been handed off.
//
// Stall: the output word sits in a register; a new input word is accepted
// while it waits. If the next sample finishes before the old word is taken,
// the core holds its result and stays busy until the register frees up.
//
// Reset (rst, synchronous): phase, smoothed pan and amplitude and the block
// position clear to zero; glide_coefficient = 6554, block_length = 1024.
// Write registers over APB only while the block is idle.
module stereo_sine_oscillator_with_glide import sso_pkg::*; #(
  parameter int PHASE_BITS       = PHASE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
  parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // APB configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // Input words
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [23:0]           phase_step,
  input  logic [15:0]           pan_target,
  input  logic [15:0]           amp_target,
  // Output words
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [15:0]    left_sample,
  output logic signed [15:0]    right_sample,
  output logic                  last_of_block
);

  typedef enum logic {REG_GLIDE, REG_BLOCK} reg_idx_t;

  logic [15:0]  glide_coefficient;
  logic [12:0]  block_length;
  logic [11:0]  block_position;

  logic         cfg_write;
  logic         in_fire;
  logic         core_ready;
  logic         core_valid;
  logic         res_take;
  logic         res_fire;
  sso_result_t  core_res;
  logic [12:0]  eff_len;
  logic         is_last;

  // APB: zero wait states, decode on the word index
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_GLIDE: prdata = {16'b0, glide_coefficient};
      REG_BLOCK: prdata = {19'b0, block_length};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      glide_coefficient <= GLIDE_RESET;
      block_length      <= BLOCK_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_GLIDE: glide_coefficient <= pwdata[15:0];
        REG_BLOCK: block_length      <= pwdata[12:0];
        default:   glide_coefficient <= glide_coefficient;
      endcase
    end
  end

  // Accept a new sample only while the core is idle
  assign in_ready = core_ready;
  assign in_fire  = in_valid && in_ready;

  sso_core #(
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_core (
    .clk               (clk),
    .rst               (rst),
    .start             (in_fire),
    .phase_step        (phase_step),
    .pan_target        (pan_target),
    .amp_target        (amp_target),
    .glide_coefficient (glide_coefficient),
    .ready             (core_ready),
    .res_valid         (core_valid),
    .res_take          (res_take),
    .res               (core_res)
  );

  // Clamp block length: zero acts as one, anything above the maximum saturates
  always_comb begin
    if (block_length == 13'd0) begin
      eff_len = 13'd1;
    end else if (block_length > MAX_BLOCK) begin
      eff_len = MAX_BLOCK;
    end else begin
      eff_len = block_length;
    end
    is_last = ({1'b0, block_position} + 13'd1) >= eff_len;
  end

  // Move the finished pair into the output register when it is empty or draining
  assign res_take = !out_valid || out_ready;
  assign res_fire = core_valid && res_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      block_position <= '0;
    end else begin
      if (res_fire) begin
        out_valid      <= 1'b1;
        block_position <= is_last ? 12'd0 : (block_position + 12'd1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      left_sample   <= core_res.left;
      right_sample  <= core_res.right;
      last_of_block <= is_last;
    end
  end

  // A sample in work blocks the input side for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("input accepted while previous sample still in work");

  // The last word of a block always leaves the position counter at zero
  a_last_clears_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_of_block) |-> (block_position == 12'd0))
    else $error("block position not cleared after last word");

  // A handed-off result shows up as a valid output word
  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    res_fire |=> out_valid)
    else $error("finished sample did not reach output register");

  // The core never holds a result while the output register is free
  a_no_idle_hold: assert property (@(posedge clk) disable iff (rst)
    (core_valid && !out_valid) |=> !core_valid)
    else $error("core result stuck with empty output register");

endmodule
